### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL, clocked on clk and
// disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/bsda_pkg.sv
// ---------------------------------------------------------------------------
// bsda_pkg
// Types, constants and the per-digit helper of the signed BCD adder.
// ---------------------------------------------------------------------------
package bsda_pkg;

  // Number format
  localparam int INT_DIGITS  = 8;
  localparam int FRAC_DIGITS = 8;
  localparam int NIBBLES     = 16;
  localparam int DIGIT_SUM   = INT_DIGITS + FRAC_DIGITS;
  localparam int DIGITS      = (DIGIT_SUM > NIBBLES) ? NIBBLES :
                               ((DIGIT_SUM < 1) ? 1 : DIGIT_SUM);
  localparam int MAG_W       = 4 * NIBBLES;
  localparam int LO_NIBBLES  = NIBBLES / 2;
  localparam int HI_NIBBLES  = NIBBLES - LO_NIBBLES;
  localparam int LO_W        = 4 * LO_NIBBLES;
  localparam int HI_W        = 4 * HI_NIBBLES;

  localparam logic [MAG_W-1:0] ACTIVE_MASK =
    (DIGITS == NIBBLES) ? {MAG_W{1'b1}} :
    ((MAG_W'(1) << (4 * DIGITS)) - MAG_W'(1));

  localparam logic [4:0] RADIX = 5'd10;
  localparam logic [3:0] MAX_DIGIT = 4'd9;

  // Input transaction
  typedef struct packed {
    logic             a_negative;
    logic [MAG_W-1:0] a_magnitude;
    logic             b_negative;
    logic [MAG_W-1:0] b_magnitude;
  } operands_t;

  // Result transaction
  typedef struct packed {
    logic             sum_negative;
    logic [MAG_W-1:0] sum_magnitude;
    logic             overflow;
    logic             bad_digit;
  } result_t;

  // One decimal digit of add or subtract: returns {carry or borrow, digit}
  function automatic logic [4:0] digit_step(input logic [3:0] x,
                                            input logic [3:0] y,
                                            input logic       cin,
                                            input logic       sub);
    logic [4:0] t;
    logic [4:0] fix;
    logic       cout;
    if (sub) begin
      t    = {1'b0, x} - {1'b0, y} - {4'b0, cin};
      cout = t[4];
      fix  = cout ? (t + RADIX) : t;
    end else begin
      t    = {1'b0, x} + {1'b0, y} + {4'b0, cin};
      cout = (t >= RADIX);
      fix  = cout ? (t - RADIX) : t;
    end
    return {cout, fix[3:0]};
  endfunction

endpackage

### rtl/core/bcd_signed_decimal_adder.sv
// ---------------------------------------------------------------------------
// bcd_signed_decimal_adder
// Sign plus packed BCD fixed-point adder/subtractor, four-stage pipeline.
// ---------------------------------------------------------------------------
// Takes one transaction per clock: busy stays low, so start may be held high
// every cycle. Each result is driven for a single cycle, with done high for
// that cycle, after the four register stages; results leave in input order.
// The four register stages are: operand masking, digit check and magnitude
// compare/swap; the low eight-digit decimal carry chain; the high eight-digit
// chain; zero detection, sign fix-up and the output register. The result
// side cannot be stalled, so the receiver must take every result as it comes.
// Equal signs add magnitudes; differing signs subtract the smaller magnitude
// from the larger and keep the sign of the larger. Zero is always positive.
module bcd_signed_decimal_adder (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bsda_pkg::operands_t operands,
  output logic                done,
  output bsda_pkg::result_t   result
);

  `include "assert_macros.svh"

  // Stage 1 registers
  logic                            s1_valid;
  logic [bsda_pkg::MAG_W-1:0]      s1_x;
  logic [bsda_pkg::MAG_W-1:0]      s1_y;
  logic                            s1_sub;
  logic                            s1_neg;
  logic                            s1_bad;

  // Stage 2 registers
  logic                            s2_valid;
  logic [bsda_pkg::LO_W-1:0]       s2_lo;
  logic [bsda_pkg::HI_W-1:0]       s2_x_hi;
  logic [bsda_pkg::HI_W-1:0]       s2_y_hi;
  logic                            s2_carry;
  logic                            s2_sub;
  logic                            s2_neg;
  logic                            s2_bad;

  // Stage 3 registers
  logic                            s3_valid;
  logic [bsda_pkg::MAG_W-1:0]      s3_raw;
  logic                            s3_carry;
  logic                            s3_sub;
  logic                            s3_neg;
  logic                            s3_bad;

  // Stage 1 combinational
  logic [bsda_pkg::MAG_W-1:0]      a_m;
  logic [bsda_pkg::MAG_W-1:0]      b_m;
  logic                            a_ge_b;
  logic                            in_sub;
  logic                            in_bad;

  // Carry chains
  logic [bsda_pkg::LO_W-1:0]       lo_digits;
  logic                            lo_carry;
  logic [bsda_pkg::HI_W-1:0]       hi_digits;
  logic                            hi_carry;

  // Output stage
  logic [bsda_pkg::MAG_W-1:0]      mag_masked;
  logic                            ovf_next;

  assign busy = 1'b0;

  // Mask operands, flag non-decimal nibbles, compare magnitudes
  always_comb begin
    a_m    = operands.a_magnitude & bsda_pkg::ACTIVE_MASK;
    b_m    = operands.b_magnitude & bsda_pkg::ACTIVE_MASK;
    a_ge_b = (a_m >= b_m);
    in_sub = operands.a_negative ^ operands.b_negative;
    in_bad = 1'b0;
    for (int i = 0; i < bsda_pkg::NIBBLES; i++) begin
      if (a_m[4*i +: 4] > bsda_pkg::MAX_DIGIT || b_m[4*i +: 4] > bsda_pkg::MAX_DIGIT) begin
        in_bad = 1'b1;
      end
    end
  end

  // Stage 1: swap so the larger magnitude is the minuend
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_sub <= in_sub;
    s1_bad <= in_bad;
    if (in_sub && !a_ge_b) begin
      s1_x   <= b_m;
      s1_y   <= a_m;
      s1_neg <= operands.b_negative;
    end else begin
      s1_x   <= a_m;
      s1_y   <= b_m;
      s1_neg <= operands.a_negative;
    end
  end

  // Low half carry chain
  always_comb begin
    logic       c;
    logic [4:0] step;
    c         = 1'b0;
    lo_digits = '0;
    for (int i = 0; i < bsda_pkg::LO_NIBBLES; i++) begin
      step              = bsda_pkg::digit_step(s1_x[4*i +: 4], s1_y[4*i +: 4], c, s1_sub);
      lo_digits[4*i +: 4] = step[3:0];
      c                 = step[4];
    end
    lo_carry = c;
  end

  // Stage 2: hold low digits and carry, pass high operand halves
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_lo    <= lo_digits;
    s2_carry <= lo_carry;
    s2_x_hi  <= s1_x[bsda_pkg::MAG_W-1:bsda_pkg::LO_W];
    s2_y_hi  <= s1_y[bsda_pkg::MAG_W-1:bsda_pkg::LO_W];
    s2_sub   <= s1_sub;
    s2_neg   <= s1_neg;
    s2_bad   <= s1_bad;
  end

  // High half carry chain
  always_comb begin
    logic       c;
    logic [4:0] step;
    c         = s2_carry;
    hi_digits = '0;
    for (int i = 0; i < bsda_pkg::HI_NIBBLES; i++) begin
      step                = bsda_pkg::digit_step(s2_x_hi[4*i +: 4], s2_y_hi[4*i +: 4],
                                                 c, s2_sub);
      hi_digits[4*i +: 4] = step[3:0];
      c                   = step[4];
    end
    hi_carry = c;
  end

  // Stage 3: assemble the raw magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_raw   <= {hi_digits, s2_lo};
    s3_carry <= hi_carry;
    s3_sub   <= s2_sub;
    s3_neg   <= s2_neg;
    s3_bad   <= s2_bad;
  end

  // Drop inactive digits; a carry out of the top active digit flags overflow
  always_comb begin
    mag_masked = s3_raw & bsda_pkg::ACTIVE_MASK;
    if (bsda_pkg::DIGITS == bsda_pkg::NIBBLES) begin
      ovf_next = s3_carry && !s3_sub;
    end else begin
      ovf_next = (|(s3_raw & ~bsda_pkg::ACTIVE_MASK)) && !s3_sub;
    end
  end

  // Stage 4: output register, zero is positive
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
    result.sum_negative  <= s3_neg && (|mag_masked);
    result.sum_magnitude <= mag_masked;
    result.overflow      <= ovf_next;
    result.bad_digit     <= s3_bad;
  end

  // Every accepted transaction yields a result with done high
  `ASSERT_CLK(a_latency, (start && !busy) |-> ##4 done, "result missing after accept")
  // A zero magnitude never carries a negative sign
  `ASSERT_IMPLY(a_zero_pos, done && (result.sum_magnitude == '0), !result.sum_negative,
                "negative zero on result")
  // Overflow only comes from an addition of like signs
  `ASSERT_IMPLY(a_ovf_add, done && result.overflow,
                $past(operands.a_negative, 4) == $past(operands.b_negative, 4),
                "overflow on a subtraction")

endmodule
